// ===== hw/rtl/h264sps_pkg.sv =====
// shared types, syntax step codes and read widths for the sps parser
package h264sps_pkg;

   typedef enum logic [5:0] {
      S_PROFILE, S_CONSTR, S_LEVEL, S_ID, S_CHROMA, S_SEPCOL, S_BDL, S_BDC,
      S_BYPASS, S_SCALPRES, S_LISTFLAG, S_DELTA, S_LOG2FN, S_POCTYPE, S_POCLSB,
      S_DELTAZERO, S_OFFNONREF, S_OFFT2B, S_NUMREF, S_REFOFF, S_NUMREFFR, S_GAPS,
      S_WIDTH, S_HEIGHT, S_FMO, S_MBAFF, S_D8, S_CROPF, S_CL, S_CR, S_CT, S_CB,
      S_VUI, S_ARF, S_ARIDC, S_SARW, S_SARH, S_OVF, S_OVA, S_VSF, S_VFMT, S_VFR,
      S_CDF, S_CD24, S_CLF, S_CLT, S_CLB, S_TIMF, S_NUIT, S_TS, S_FFR, S_DONE
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_SHIFT, ST_FLUSH, ST_EMIT
   } ctrl_type;

   typedef struct packed {
      logic done;
      logic err;
   } core_status_type;

   localparam int unsigned NUM_FIELDS  = 20;
   localparam logic [4:0]  LAST_CODE   = 5'd24;
   localparam logic [4:0]  STATUS_CODE = 5'd0;
   localparam logic [2:0]  MIN_BYTES   = 3'd4;

   // fixed read width of a step, zero for an exp-golomb code
   function automatic logic [5:0] read_len(input step_type s);
      logic [5:0] n;
      unique case (s)
         S_PROFILE, S_CONSTR, S_LEVEL, S_ARIDC: n = 6'd8;
         S_SARW, S_SARH:                        n = 6'd16;
         S_CD24:                                n = 6'd24;
         S_NUIT, S_TS:                          n = 6'd32;
         S_VFMT:                                n = 6'd4;
         S_SEPCOL, S_BYPASS, S_SCALPRES, S_LISTFLAG, S_DELTAZERO, S_GAPS,
         S_FMO, S_MBAFF, S_D8, S_CROPF, S_VUI, S_ARF, S_OVF, S_OVA, S_VSF,
         S_VFR, S_CDF, S_CLF, S_TIMF, S_FFR:    n = 6'd1;
         default:                               n = 6'd0;
      endcase
      return n;
   endfunction

   function automatic logic high_profile(input logic [31:0] p);
      return p == 32'd100 || p == 32'd110 || p == 32'd122 || p == 32'd244 ||
             p == 32'd44  || p == 32'd83  || p == 32'd86  || p == 32'd118 ||
             p == 32'd128 || p == 32'd138 || p == 32'd139 || p == 32'd134 ||
             p == 32'd135;
   endfunction

endpackage

// ===== hw/rtl/h264sps_syntax.sv =====
// bit-serial syntax engine: one header bit per cycle while bit_en or flush feeds it, field store and derived sizes
module h264sps_syntax (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         bit_en,
   input  logic                         bit_val,
   input  logic                         flush,
   input  logic [4:0]                   rd_sel,
   output logic [31:0]                  rd_value,
   output h264sps_pkg::core_status_type status
);

   h264sps_pkg::step_type step_ff, step_in;
   logic [4:0]  zr_ff, zr_in;
   logic        suf_ff, suf_in;
   logic [5:0]  bc_ff, bc_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  li_ff, li_in;
   logic [6:0]  le_ff, le_in;
   logic [7:0]  sn_ff, sn_in;
   logic [7:0]  sl_ff, sl_in;
   logic [31:0] lc_ff, lc_in;
   logic        err_ff, err_in;
   logic [31:0] fld_ff [h264sps_pkg::NUM_FIELDS];
   logic [31:0] fld_in [h264sps_pkg::NUM_FIELDS];

   always_comb begin
      logic        fin;
      logic [31:0] v;
      logic        fb;
      logic        feed;
      logic [31:0] acc_next;
      logic [5:0]  bc_next;
      logic [5:0]  len;
      logic [31:0] h;
      logic [31:0] d;
      logic [7:0]  sn;
      logic [6:0]  le;
      logic [3:0]  li;
      logic        idle;
      step_in = step_ff; zr_in = zr_ff; suf_in = suf_ff; bc_in = bc_ff;
      acc_in = acc_ff; li_in = li_ff; le_in = le_ff; sn_in = sn_ff;
      sl_in = sl_ff; lc_in = lc_ff; err_in = err_ff; fld_in = fld_ff;
      fin = 1'b0; v = '0; feed = 1'b0; fb = 1'b0;
      acc_next = {acc_ff[30:0], fb}; bc_next = bc_ff + 6'd1;
      len = h264sps_pkg::read_len(step_ff);
      h = '0; d = '0; sn = '0; le = '0; li = li_ff + 4'd1;
      idle = zr_ff == 5'd0 && !suf_ff && bc_ff == 6'd0;
      if (step_ff != h264sps_pkg::S_DONE) begin
         // skip pending loops once past the end of the unit
         priority if (flush && idle && (step_ff == h264sps_pkg::S_LISTFLAG ||
                                        step_ff == h264sps_pkg::S_DELTA)) begin
            step_in = h264sps_pkg::S_LOG2FN;
         end else if (flush && idle && step_ff == h264sps_pkg::S_REFOFF) begin
            step_in = h264sps_pkg::S_NUMREFFR;
         end else if (bit_en || flush) begin
            feed = 1'b1;
            fb   = !flush && bit_val;
         end else begin
            feed = 1'b0;
         end
      end
      acc_next = {acc_ff[30:0], fb};
      if (feed) begin
         if (len == 6'd0) begin
            if (!suf_ff) begin
               priority if (!fb && zr_ff < 5'd31) begin
                  zr_in = zr_ff + 5'd1;
               end else if (zr_ff == 5'd0) begin
                  fin = 1'b1;
               end else begin
                  suf_in = 1'b1; bc_in = '0; acc_in = '0;
               end
            end else begin
               acc_in = acc_next; bc_in = bc_next;
               if (bc_next >= {1'b0, zr_ff}) begin
                  fin = 1'b1;
                  v   = ((32'd1 << zr_ff) - 32'd1) + acc_next;
               end
            end
         end else begin
            acc_in = acc_next; bc_in = bc_next;
            if (bc_next >= len) begin
               fin = 1'b1;
               v   = acc_next;
            end
         end
      end
      if (fin) begin
         zr_in = '0; acc_in = '0; suf_in = 1'b0; bc_in = '0;
         unique case (step_ff)
            h264sps_pkg::S_PROFILE: begin fld_in[0] = v; step_in = h264sps_pkg::S_CONSTR; end
            h264sps_pkg::S_CONSTR:  begin fld_in[1] = v; step_in = h264sps_pkg::S_LEVEL; end
            h264sps_pkg::S_LEVEL:   begin fld_in[2] = v; step_in = h264sps_pkg::S_ID; end
            h264sps_pkg::S_ID: begin
               fld_in[3] = v;
               priority if (v >= 32'd32) begin
                  err_in = 1'b1; step_in = h264sps_pkg::S_DONE;
               end else if (h264sps_pkg::high_profile(fld_ff[0])) begin
                  step_in = h264sps_pkg::S_CHROMA;
               end else begin
                  fld_in[4] = 32'd1; step_in = h264sps_pkg::S_LOG2FN;
               end
            end
            h264sps_pkg::S_CHROMA: begin
               fld_in[4] = v;
               step_in = (v == 32'd3) ? h264sps_pkg::S_SEPCOL : h264sps_pkg::S_BDL;
            end
            h264sps_pkg::S_SEPCOL: step_in = h264sps_pkg::S_BDL;
            h264sps_pkg::S_BDL: begin fld_in[5] = v; step_in = h264sps_pkg::S_BDC; end
            h264sps_pkg::S_BDC: begin fld_in[6] = v; step_in = h264sps_pkg::S_BYPASS; end
            h264sps_pkg::S_BYPASS: step_in = h264sps_pkg::S_SCALPRES;
            h264sps_pkg::S_SCALPRES: begin
               if (v[0]) begin
                  li_in = '0; step_in = h264sps_pkg::S_LISTFLAG;
               end else begin
                  step_in = h264sps_pkg::S_LOG2FN;
               end
            end
            h264sps_pkg::S_LISTFLAG: begin
               if (v[0]) begin
                  // fresh list always starts with a delta read
                  le_in = '0; sn_in = 8'd8; sl_in = 8'd8;
                  step_in = h264sps_pkg::S_DELTA;
               end else begin
                  li_in = li;
                  step_in = (li < ((fld_ff[4] != 32'd3) ? 4'd8 : 4'd12)) ?
                            h264sps_pkg::S_LISTFLAG : h264sps_pkg::S_LOG2FN;
               end
            end
            h264sps_pkg::S_DELTA: begin
               h  = (v >> 1) + {31'd0, v[0]};
               d  = v[0] ? (32'd0 - h) : h;
               sn = sl_ff + d[7:0];
               sn_in = sn;
               if (sn != 8'd0) sl_in = sn;
               le = le_ff + 7'd1;
               le_in = le;
               if (sn != 8'd0 && le < ((li_ff < 4'd6) ? 7'd16 : 7'd64)) begin
                  step_in = h264sps_pkg::S_DELTA;
               end else begin
                  li_in = li;
                  step_in = (li < ((fld_ff[4] != 32'd3) ? 4'd8 : 4'd12)) ?
                            h264sps_pkg::S_LISTFLAG : h264sps_pkg::S_LOG2FN;
               end
            end
            h264sps_pkg::S_LOG2FN: step_in = h264sps_pkg::S_POCTYPE;
            h264sps_pkg::S_POCTYPE: begin
               step_in = (v == 32'd0) ? h264sps_pkg::S_POCLSB :
                         (v == 32'd1) ? h264sps_pkg::S_DELTAZERO : h264sps_pkg::S_NUMREFFR;
            end
            h264sps_pkg::S_POCLSB:    step_in = h264sps_pkg::S_NUMREFFR;
            h264sps_pkg::S_DELTAZERO: step_in = h264sps_pkg::S_OFFNONREF;
            h264sps_pkg::S_OFFNONREF: step_in = h264sps_pkg::S_OFFT2B;
            h264sps_pkg::S_OFFT2B:    step_in = h264sps_pkg::S_NUMREF;
            h264sps_pkg::S_NUMREF: begin
               lc_in = v;
               step_in = (v != 32'd0) ? h264sps_pkg::S_REFOFF : h264sps_pkg::S_NUMREFFR;
            end
            h264sps_pkg::S_REFOFF: begin
               lc_in = lc_ff - 32'd1;
               if (lc_ff == 32'd1) step_in = h264sps_pkg::S_NUMREFFR;
            end
            h264sps_pkg::S_NUMREFFR: step_in = h264sps_pkg::S_GAPS;
            h264sps_pkg::S_GAPS:     step_in = h264sps_pkg::S_WIDTH;
            h264sps_pkg::S_WIDTH:  begin fld_in[7] = v; step_in = h264sps_pkg::S_HEIGHT; end
            h264sps_pkg::S_HEIGHT: begin fld_in[8] = v; step_in = h264sps_pkg::S_FMO; end
            h264sps_pkg::S_FMO: begin
               fld_in[9] = v;
               step_in = v[0] ? h264sps_pkg::S_D8 : h264sps_pkg::S_MBAFF;
            end
            h264sps_pkg::S_MBAFF: step_in = h264sps_pkg::S_D8;
            h264sps_pkg::S_D8:    step_in = h264sps_pkg::S_CROPF;
            h264sps_pkg::S_CROPF: begin
               fld_in[10] = v;
               step_in = v[0] ? h264sps_pkg::S_CL : h264sps_pkg::S_VUI;
            end
            h264sps_pkg::S_CL: begin fld_in[11] = v; step_in = h264sps_pkg::S_CR; end
            h264sps_pkg::S_CR: begin fld_in[12] = v; step_in = h264sps_pkg::S_CT; end
            h264sps_pkg::S_CT: begin fld_in[13] = v; step_in = h264sps_pkg::S_CB; end
            h264sps_pkg::S_CB: begin fld_in[14] = v; step_in = h264sps_pkg::S_VUI; end
            h264sps_pkg::S_VUI: begin
               fld_in[15] = v;
               step_in = v[0] ? h264sps_pkg::S_ARF : h264sps_pkg::S_DONE;
            end
            h264sps_pkg::S_ARF:
               step_in = v[0] ? h264sps_pkg::S_ARIDC : h264sps_pkg::S_OVF;
            h264sps_pkg::S_ARIDC:
               step_in = (v == 32'd255) ? h264sps_pkg::S_SARW : h264sps_pkg::S_OVF;
            h264sps_pkg::S_SARW: step_in = h264sps_pkg::S_SARH;
            h264sps_pkg::S_SARH: step_in = h264sps_pkg::S_OVF;
            h264sps_pkg::S_OVF:
               step_in = v[0] ? h264sps_pkg::S_OVA : h264sps_pkg::S_VSF;
            h264sps_pkg::S_OVA:  step_in = h264sps_pkg::S_VSF;
            h264sps_pkg::S_VSF:
               step_in = v[0] ? h264sps_pkg::S_VFMT : h264sps_pkg::S_CLF;
            h264sps_pkg::S_VFMT: step_in = h264sps_pkg::S_VFR;
            h264sps_pkg::S_VFR:  step_in = h264sps_pkg::S_CDF;
            h264sps_pkg::S_CDF:
               step_in = v[0] ? h264sps_pkg::S_CD24 : h264sps_pkg::S_CLF;
            h264sps_pkg::S_CD24: step_in = h264sps_pkg::S_CLF;
            h264sps_pkg::S_CLF:
               step_in = v[0] ? h264sps_pkg::S_CLT : h264sps_pkg::S_TIMF;
            h264sps_pkg::S_CLT:  step_in = h264sps_pkg::S_CLB;
            h264sps_pkg::S_CLB:  step_in = h264sps_pkg::S_TIMF;
            h264sps_pkg::S_TIMF: begin
               fld_in[16] = v;
               step_in = v[0] ? h264sps_pkg::S_NUIT : h264sps_pkg::S_DONE;
            end
            h264sps_pkg::S_NUIT: begin fld_in[17] = v; step_in = h264sps_pkg::S_TS; end
            h264sps_pkg::S_TS:   begin fld_in[18] = v; step_in = h264sps_pkg::S_FFR; end
            h264sps_pkg::S_FFR:  begin fld_in[19] = v; step_in = h264sps_pkg::S_DONE; end
            default: step_in = h264sps_pkg::S_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         step_ff <= h264sps_pkg::S_PROFILE;
         zr_ff <= '0; suf_ff <= 1'b0; bc_ff <= '0; acc_ff <= '0;
         li_ff <= '0; le_ff <= '0; sn_ff <= 8'd8; sl_ff <= 8'd8;
         lc_ff <= '0; err_ff <= 1'b0;
         for (int i = 0; i < h264sps_pkg::NUM_FIELDS; i++) fld_ff[i] <= '0;
      end else begin
         step_ff <= step_in;
         zr_ff <= zr_in; suf_ff <= suf_in; bc_ff <= bc_in; acc_ff <= acc_in;
         li_ff <= li_in; le_ff <= le_in; sn_ff <= sn_in; sl_ff <= sl_in;
         lc_ff <= lc_in; err_ff <= err_in;
         fld_ff <= fld_in;
      end
   end

   // derived macroblock and pixel sizes, wrapped at 32 bits
   logic [31:0] mb_w, mb_h;
   assign mb_w = fld_ff[7] + 32'd1;
   assign mb_h = (fld_ff[8] + 32'd1) << (fld_ff[9] != 32'd0 ? 1'b0 : 1'b1);

   always_comb begin
      unique case (rd_sel)
         5'd20:   rd_value = mb_w;
         5'd21:   rd_value = mb_h;
         5'd22:   rd_value = (mb_w << 4) - ((fld_ff[11] + fld_ff[12]) << 1);
         5'd23:   rd_value = (mb_h << 4) - ((fld_ff[13] + fld_ff[14]) << 1);
         default: rd_value = (rd_sel < 5'd20) ? fld_ff[rd_sel] : 32'd0;
      endcase
   end

   assign status.done = step_ff == h264sps_pkg::S_DONE;
   assign status.err  = err_ff;

endmodule

// ===== hw/rtl/h264_sps_header_parser.sv =====
// h264 sequence parameter set parser top level: byte intake, control and result register
// each request byte is accepted in ST_IDLE and shifted msb first in ST_SHIFT, one bit per
// cycle, and no byte is taken while one is shifting. After the last byte of a unit of
// four or more bytes, the remaining syntax is finished with zero bits, one per cycle; then
// 25 results (or 1 error result) leave at up to one per cycle, as rsp_tready allows
// reset: synchronous, active high; parser returns to the start of the header
module h264_sps_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // field_code [4:0], field_value [36:5], zero pad
   output logic        rsp_tlast    // final_result
);

   h264sps_pkg::ctrl_type state_ff, state_in;
   logic [7:0]  shift_ff, shift_in;     // byte being fed msb first
   logic [2:0]  cnt_ff, cnt_in;         // bits still to feed after the current one
   logic        last_ff, last_in;       // current byte ends the unit
   logic [2:0]  bytes_ff, bytes_in;     // byte count, saturates at four
   logic        short_ff, short_in;     // unit was too short
   logic [4:0]  idx_ff, idx_in;         // next result code to emit
   logic        rv_ff, rv_in;
   logic [4:0]  rcode_ff, rcode_in;
   logic [31:0] rval_ff, rval_in;
   logic        rlast_ff, rlast_in;

   logic        core_clear, bit_en, flush, err_any, slot_free;
   logic [31:0] rd_value;
   h264sps_pkg::core_status_type core_st;

   h264sps_syntax u_syntax (
      .clock    (clock),
      .reset    (reset),
      .clear    (core_clear),
      .bit_en   (bit_en),
      .bit_val  (shift_ff[7]),
      .flush    (flush),
      .rd_sel   (idx_ff - 5'd1),
      .rd_value (rd_value),
      .status   (core_st)
   );

   assign err_any   = short_ff || core_st.err;
   assign slot_free = !rv_ff || rsp_tready;

   always_comb begin
      state_in = state_ff; shift_in = shift_ff; cnt_in = cnt_ff; last_in = last_ff;
      bytes_in = bytes_ff; short_in = short_ff; idx_in = idx_ff;
      rv_in = rv_ff && !rsp_tready;
      rcode_in = rcode_ff; rval_in = rval_ff; rlast_in = rlast_ff;
      req_tready = 1'b0; bit_en = 1'b0; flush = 1'b0; core_clear = 1'b0;
      unique case (state_ff)
         h264sps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               shift_in = req_tdata;
               cnt_in   = 3'd7;
               last_in  = req_tlast;
               if (bytes_ff < h264sps_pkg::MIN_BYTES) bytes_in = bytes_ff + 3'd1;
               state_in = h264sps_pkg::ST_SHIFT;
            end
         end
         h264sps_pkg::ST_SHIFT: begin
            bit_en   = 1'b1;
            shift_in = {shift_ff[6:0], 1'b0};
            cnt_in   = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               priority if (!last_ff) begin
                  state_in = h264sps_pkg::ST_IDLE;
               end else if (bytes_ff < h264sps_pkg::MIN_BYTES) begin
                  short_in = 1'b1;
                  idx_in   = h264sps_pkg::STATUS_CODE;
                  state_in = h264sps_pkg::ST_EMIT;
               end else begin
                  state_in = h264sps_pkg::ST_FLUSH;
               end
            end
         end
         h264sps_pkg::ST_FLUSH: begin
            // zero bits until the syntax completes
            flush = 1'b1;
            if (core_st.done) begin
               idx_in   = h264sps_pkg::STATUS_CODE;
               state_in = h264sps_pkg::ST_EMIT;
            end
         end
         h264sps_pkg::ST_EMIT: begin
            if (slot_free) begin
               rv_in    = 1'b1;
               rcode_in = idx_ff;
               rval_in  = (idx_ff == h264sps_pkg::STATUS_CODE) ? {31'd0, err_any} : rd_value;
               rlast_in = err_any || idx_ff == h264sps_pkg::LAST_CODE;
               if (rlast_in) begin
                  // run finished: back to the start of the header
                  core_clear = 1'b1;
                  bytes_in   = '0;
                  short_in   = 1'b0;
                  idx_in     = '0;
                  state_in   = h264sps_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         default: state_in = h264sps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= h264sps_pkg::ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         bytes_ff <= '0;
         short_ff <= 1'b0;
         idx_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         bytes_ff <= bytes_in;
         short_ff <= short_in;
         idx_ff   <= idx_in;
         rv_ff    <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rcode_ff <= rcode_in;
      rval_ff  <= rval_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'd0, rval_ff, rcode_ff};
   assign rsp_tlast  = rlast_ff;

`ifndef NO_ASSERTIONS
   // a final status result is the error result
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[4:0] == h264sps_pkg::STATUS_CODE
      |-> rsp_tdata[36:5] == 32'd1)
      else $error("error result without error value");

   // a normal run ends on the last field code
   a_last_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[4:0] != h264sps_pkg::STATUS_CODE
      |-> rsp_tdata[4:0] == h264sps_pkg::LAST_CODE)
      else $error("final result on wrong code");

   // an accepted request blocks intake while its bits are fed
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while shifting");
`endif

endmodule

// ===== sim/h264_sps_header_parser_tb.sv =====
// self-checking testbench for the h264 sps header parser: stream driver, monitor, predictor
module h264_sps_header_parser_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // one request byte waiting to be driven
   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         hold;   // wait until every expected field has come before sending
   } byte_rec_type;

   // one expected result
   typedef struct {
      logic [4:0]  code;
      logic [31:0] value;
      logic        last;
   } field_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // data_byte
   logic        req_tlast = 1'b0;   // end_of_unit
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // field_code [4:0], field_value [36:5], zero pad
   logic        rsp_tlast;          // final_result

   byte_rec_type  byte_q[$];
   field_rec_type field_q[$];
   bit            bit_q[$];
   int            fail_count = 0;
   int            cycle_count = 0;

   // parser shadow state
   h264sps_pkg::step_type sp_step;
   logic [2:0]  sp_bytes;
   logic [4:0]  sp_zeros;
   logic [31:0] sp_accum;
   bit          sp_suffix;
   int          sp_nbits;
   logic [3:0]  sp_list;
   logic [6:0]  sp_entry;
   logic [7:0]  sp_next;
   logic [7:0]  sp_last;
   logic [31:0] sp_refs;
   logic [31:0] sp_fld [20];
   bit          sp_err;

   h264_sps_header_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function void clear_parser();
      sp_step = h264sps_pkg::S_PROFILE;
      sp_bytes = 0;
      sp_zeros = 0;
      sp_accum = 0;
      sp_suffix = 0;
      sp_nbits = 0;
      sp_list = 0;
      sp_entry = 0;
      sp_next = 8;
      sp_last = 8;
      sp_refs = 0;
      sp_err = 0;
      foreach (sp_fld[i]) sp_fld[i] = 0;
   endfunction

   // fixed bit width of a syntax element, zero for exp-golomb
   function int step_width(h264sps_pkg::step_type s);
      case (s)
         h264sps_pkg::S_PROFILE, h264sps_pkg::S_CONSTR, h264sps_pkg::S_LEVEL,
         h264sps_pkg::S_ARIDC:
            return 8;
         h264sps_pkg::S_SARW, h264sps_pkg::S_SARH: return 16;
         h264sps_pkg::S_CD24:                      return 24;
         h264sps_pkg::S_NUIT, h264sps_pkg::S_TS:   return 32;
         h264sps_pkg::S_VFMT:                      return 4;
         h264sps_pkg::S_SEPCOL, h264sps_pkg::S_BYPASS, h264sps_pkg::S_SCALPRES,
         h264sps_pkg::S_LISTFLAG, h264sps_pkg::S_DELTAZERO, h264sps_pkg::S_GAPS,
         h264sps_pkg::S_FMO, h264sps_pkg::S_MBAFF, h264sps_pkg::S_D8,
         h264sps_pkg::S_CROPF, h264sps_pkg::S_VUI, h264sps_pkg::S_ARF,
         h264sps_pkg::S_OVF, h264sps_pkg::S_OVA, h264sps_pkg::S_VSF,
         h264sps_pkg::S_VFR, h264sps_pkg::S_CDF, h264sps_pkg::S_CLF,
         h264sps_pkg::S_TIMF, h264sps_pkg::S_FFR:
            return 1;
         default: return 0;
      endcase
   endfunction

   // profiles that carry chroma, bit depth and scaling syntax
   function bit has_chroma_syntax(logic [31:0] p);
      return p == 100 || p == 110 || p == 122 || p == 244 || p == 44 ||
             p == 83 || p == 86 || p == 118 || p == 128 || p == 138 ||
             p == 139 || p == 134 || p == 135;
   endfunction

   function void next_scaling_list();
      sp_list = sp_list + 4'd1;
      sp_step = (sp_list < ((sp_fld[4] != 3) ? 8 : 12)) ? h264sps_pkg::S_LISTFLAG
                                                         : h264sps_pkg::S_LOG2FN;
   endfunction

   function void walk_scaling_list();
      if (sp_next != 0 && sp_entry < ((sp_list < 6) ? 16 : 64))
         sp_step = h264sps_pkg::S_DELTA;
      else
         next_scaling_list();
   endfunction

   // store a finished syntax element and pick the next one
   function void end_element(logic [31:0] v);
      logic [31:0] h;
      logic [31:0] d;
      sp_zeros = 0;
      sp_accum = 0;
      sp_suffix = 0;
      sp_nbits = 0;
      case (sp_step)
         h264sps_pkg::S_PROFILE: begin sp_fld[0] = v; sp_step = h264sps_pkg::S_CONSTR; end
         h264sps_pkg::S_CONSTR:  begin sp_fld[1] = v; sp_step = h264sps_pkg::S_LEVEL; end
         h264sps_pkg::S_LEVEL:   begin sp_fld[2] = v; sp_step = h264sps_pkg::S_ID; end
         h264sps_pkg::S_ID: begin
            sp_fld[3] = v;
            if (v >= 32) begin
               sp_err = 1;
               sp_step = h264sps_pkg::S_DONE;
            end else if (has_chroma_syntax(sp_fld[0])) begin
               sp_step = h264sps_pkg::S_CHROMA;
            end else begin
               sp_fld[4] = 1;
               sp_step = h264sps_pkg::S_LOG2FN;
            end
         end
         h264sps_pkg::S_CHROMA: begin
            sp_fld[4] = v;
            sp_step = (v == 3) ? h264sps_pkg::S_SEPCOL : h264sps_pkg::S_BDL;
         end
         h264sps_pkg::S_SEPCOL: sp_step = h264sps_pkg::S_BDL;
         h264sps_pkg::S_BDL:    begin sp_fld[5] = v; sp_step = h264sps_pkg::S_BDC; end
         h264sps_pkg::S_BDC:    begin sp_fld[6] = v; sp_step = h264sps_pkg::S_BYPASS; end
         h264sps_pkg::S_BYPASS: sp_step = h264sps_pkg::S_SCALPRES;
         h264sps_pkg::S_SCALPRES: begin
            if (v != 0) begin
               sp_list = 0;
               sp_step = h264sps_pkg::S_LISTFLAG;
            end else begin
               sp_step = h264sps_pkg::S_LOG2FN;
            end
         end
         h264sps_pkg::S_LISTFLAG: begin
            if (v != 0) begin
               sp_entry = 0;
               sp_next = 8;
               sp_last = 8;
               walk_scaling_list();
            end else begin
               next_scaling_list();
            end
         end
         h264sps_pkg::S_DELTA: begin
            // odd codes are negative deltas here, scale wraps mod 256
            h = (v >> 1) + v[0];
            d = v[0] ? -h : h;
            sp_next = sp_last + d[7:0];
            if (sp_next != 0) sp_last = sp_next;
            sp_entry = sp_entry + 7'd1;
            walk_scaling_list();
         end
         h264sps_pkg::S_LOG2FN: sp_step = h264sps_pkg::S_POCTYPE;
         h264sps_pkg::S_POCTYPE:
            sp_step = (v == 0) ? h264sps_pkg::S_POCLSB :
                      (v == 1) ? h264sps_pkg::S_DELTAZERO : h264sps_pkg::S_NUMREFFR;
         h264sps_pkg::S_POCLSB:    sp_step = h264sps_pkg::S_NUMREFFR;
         h264sps_pkg::S_DELTAZERO: sp_step = h264sps_pkg::S_OFFNONREF;
         h264sps_pkg::S_OFFNONREF: sp_step = h264sps_pkg::S_OFFT2B;
         h264sps_pkg::S_OFFT2B:    sp_step = h264sps_pkg::S_NUMREF;
         h264sps_pkg::S_NUMREF: begin
            sp_refs = v;
            sp_step = (v != 0) ? h264sps_pkg::S_REFOFF : h264sps_pkg::S_NUMREFFR;
         end
         h264sps_pkg::S_REFOFF: begin
            sp_refs = sp_refs - 1;
            if (sp_refs == 0) sp_step = h264sps_pkg::S_NUMREFFR;
         end
         h264sps_pkg::S_NUMREFFR: sp_step = h264sps_pkg::S_GAPS;
         h264sps_pkg::S_GAPS:     sp_step = h264sps_pkg::S_WIDTH;
         h264sps_pkg::S_WIDTH:  begin sp_fld[7] = v; sp_step = h264sps_pkg::S_HEIGHT; end
         h264sps_pkg::S_HEIGHT: begin sp_fld[8] = v; sp_step = h264sps_pkg::S_FMO; end
         h264sps_pkg::S_FMO: begin
            sp_fld[9] = v;
            sp_step = (v != 0) ? h264sps_pkg::S_D8 : h264sps_pkg::S_MBAFF;
         end
         h264sps_pkg::S_MBAFF: sp_step = h264sps_pkg::S_D8;
         h264sps_pkg::S_D8:    sp_step = h264sps_pkg::S_CROPF;
         h264sps_pkg::S_CROPF: begin
            sp_fld[10] = v;
            sp_step = (v != 0) ? h264sps_pkg::S_CL : h264sps_pkg::S_VUI;
         end
         h264sps_pkg::S_CL: begin sp_fld[11] = v; sp_step = h264sps_pkg::S_CR; end
         h264sps_pkg::S_CR: begin sp_fld[12] = v; sp_step = h264sps_pkg::S_CT; end
         h264sps_pkg::S_CT: begin sp_fld[13] = v; sp_step = h264sps_pkg::S_CB; end
         h264sps_pkg::S_CB: begin sp_fld[14] = v; sp_step = h264sps_pkg::S_VUI; end
         h264sps_pkg::S_VUI: begin
            sp_fld[15] = v;
            sp_step = (v != 0) ? h264sps_pkg::S_ARF : h264sps_pkg::S_DONE;
         end
         h264sps_pkg::S_ARF:
            sp_step = (v != 0) ? h264sps_pkg::S_ARIDC : h264sps_pkg::S_OVF;
         h264sps_pkg::S_ARIDC:
            sp_step = (v == 255) ? h264sps_pkg::S_SARW : h264sps_pkg::S_OVF;
         h264sps_pkg::S_SARW: sp_step = h264sps_pkg::S_SARH;
         h264sps_pkg::S_SARH: sp_step = h264sps_pkg::S_OVF;
         h264sps_pkg::S_OVF:
            sp_step = (v != 0) ? h264sps_pkg::S_OVA : h264sps_pkg::S_VSF;
         h264sps_pkg::S_OVA:  sp_step = h264sps_pkg::S_VSF;
         h264sps_pkg::S_VSF:
            sp_step = (v != 0) ? h264sps_pkg::S_VFMT : h264sps_pkg::S_CLF;
         h264sps_pkg::S_VFMT: sp_step = h264sps_pkg::S_VFR;
         h264sps_pkg::S_VFR:  sp_step = h264sps_pkg::S_CDF;
         h264sps_pkg::S_CDF:
            sp_step = (v != 0) ? h264sps_pkg::S_CD24 : h264sps_pkg::S_CLF;
         h264sps_pkg::S_CD24: sp_step = h264sps_pkg::S_CLF;
         h264sps_pkg::S_CLF:
            sp_step = (v != 0) ? h264sps_pkg::S_CLT : h264sps_pkg::S_TIMF;
         h264sps_pkg::S_CLT:  sp_step = h264sps_pkg::S_CLB;
         h264sps_pkg::S_CLB:  sp_step = h264sps_pkg::S_TIMF;
         h264sps_pkg::S_TIMF: begin
            sp_fld[16] = v;
            sp_step = (v != 0) ? h264sps_pkg::S_NUIT : h264sps_pkg::S_DONE;
         end
         h264sps_pkg::S_NUIT: begin sp_fld[17] = v; sp_step = h264sps_pkg::S_TS; end
         h264sps_pkg::S_TS:   begin sp_fld[18] = v; sp_step = h264sps_pkg::S_FFR; end
         h264sps_pkg::S_FFR:  begin sp_fld[19] = v; sp_step = h264sps_pkg::S_DONE; end
         default: sp_step = h264sps_pkg::S_DONE;
      endcase
   endfunction

   // one header bit through the syntax machine
   function void parse_bit(bit b);
      int w;
      if (sp_step == h264sps_pkg::S_DONE) return;
      w = step_width(sp_step);
      if (w == 0) begin
         if (!sp_suffix) begin
            // zero prefix capped at 31, the next bit then opens the suffix
            if (!b && sp_zeros < 31) begin
               sp_zeros = sp_zeros + 5'd1;
               return;
            end
            if (sp_zeros == 0) begin
               end_element(0);
               return;
            end
            sp_suffix = 1;
            sp_nbits = 0;
            sp_accum = 0;
            return;
         end
         sp_accum = {sp_accum[30:0], b};
         sp_nbits++;
         if (sp_nbits >= sp_zeros)
            end_element(((32'd1 << sp_zeros) - 32'd1) + sp_accum);
         return;
      end
      sp_accum = {sp_accum[30:0], b};
      sp_nbits++;
      if (sp_nbits >= w) end_element(sp_accum);
   endfunction

   // work out the fields that an accepted request byte releases
   function void predict_byte(logic [7:0] data, logic last);
      logic [31:0] f [24];
      bit idle;
      for (int i = 7; i >= 0; i--) parse_bit(data[i]);
      if (sp_bytes < 4) sp_bytes = sp_bytes + 3'd1;
      if (!last) return;
      if (sp_bytes < h264sps_pkg::MIN_BYTES) begin
         sp_err = 1;
      end else begin
         // finish the syntax with zero bits, pending loops are skipped
         while (sp_step != h264sps_pkg::S_DONE) begin
            idle = sp_zeros == 0 && !sp_suffix && sp_nbits == 0;
            if (idle && (sp_step == h264sps_pkg::S_LISTFLAG ||
                         sp_step == h264sps_pkg::S_DELTA))
               sp_step = h264sps_pkg::S_LOG2FN;
            else if (idle && sp_step == h264sps_pkg::S_REFOFF)
               sp_step = h264sps_pkg::S_NUMREFFR;
            else
               parse_bit(1'b0);
         end
      end
      if (sp_err) begin
         field_q.push_back('{h264sps_pkg::STATUS_CODE, 32'd1, 1'b1});
      end else begin
         for (int i = 0; i < 20; i++) f[i] = sp_fld[i];
         f[20] = sp_fld[7] + 1;
         f[21] = (sp_fld[8] + 1) * (sp_fld[9] != 0 ? 32'd1 : 32'd2);
         f[22] = f[20] * 16 - (sp_fld[11] + sp_fld[12]) * 2;
         f[23] = f[21] * 16 - (sp_fld[13] + sp_fld[14]) * 2;
         field_q.push_back('{h264sps_pkg::STATUS_CODE, 32'd0, 1'b0});
         for (int i = 0; i < 24; i++)
            field_q.push_back('{5'(i + 1), f[i], 5'(i + 1) == h264sps_pkg::LAST_CODE});
      end
      clear_parser();
   endfunction

   // ---------------------------------------------------------------
   // stimulus building: bit writer, exp-golomb coder, unit packer
   // ---------------------------------------------------------------

   task put_bits(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--) bit_q.push_back(v[i]);
   endtask

   task put_ue(logic [31:0] v);
      logic [32:0] c;
      int len;
      c = {1'b0, v} + 33'd1;
      len = 0;
      for (int i = 0; i < 33; i++) if (c[i]) len = i + 1;
      for (int i = 0; i < len - 1; i++) bit_q.push_back(1'b0);
      for (int i = len - 1; i >= 0; i--) bit_q.push_back(c[i]);
   endtask

   function logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return $urandom_range(1, 20);
         2:       return $urandom_range(0, 5000);
         3:       return $urandom_range(0, 300);
         default: return $urandom;
      endcase
   endfunction

   // turn the bit queue into request bytes; optional cut and trailing bytes
   task pack_unit(bit hold, bit may_cut);
      int n;
      int extra;
      if (may_cut && bit_q.size() > 40 && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(32, bit_q.size() - 1);
         while (bit_q.size() > n) void'(bit_q.pop_back());
      end
      while (bit_q.size() % 8 != 0) bit_q.push_back($urandom_range(0, 1));
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < extra * 8; i++) bit_q.push_back($urandom_range(0, 1));
      n = bit_q.size() / 8;
      for (int k = 0; k < n; k++) begin
         byte_rec_type r;
         for (int i = 7; i >= 0; i--) r.data[i] = bit_q.pop_front();
         r.last = (k == n - 1);
         r.hold = hold && k == 0;
         byte_q.push_back(r);
      end
   endtask

   // one parameter set with random content, sometimes with an out-of-range id
   task build_sps();
      logic [31:0] prof;
      logic [31:0] chroma;
      logic [31:0] poc;
      logic [31:0] nref;
      logic [7:0]  lastv;
      logic [7:0]  nextv;
      int d;
      int dc;
      int lists;
      case ($urandom_range(0, 5))
         0: prof = 66;
         1: prof = 77;
         2: prof = $urandom_range(0, 255);
         default: begin
            case ($urandom_range(0, 12))
               0: prof = 100;  1: prof = 110;  2: prof = 122;  3: prof = 244;
               4: prof = 44;   5: prof = 83;   6: prof = 86;   7: prof = 118;
               8: prof = 128;  9: prof = 138;  10: prof = 139; 11: prof = 134;
               default: prof = 135;
            endcase
         end
      endcase
      put_bits(prof, 8);
      put_bits($urandom, 8);
      put_bits($urandom, 8);
      put_ue(($urandom_range(0, 7) == 0) ? $urandom_range(32, 2000) : $urandom_range(0, 31));
      if (has_chroma_syntax(prof)) begin
         chroma = $urandom_range(0, 3);
         put_ue(chroma);
         if (chroma == 3) put_bits($urandom, 1);
         put_ue($urandom_range(0, 8));
         put_ue($urandom_range(0, 8));
         put_bits($urandom, 1);
         if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            lists = (chroma == 3) ? 12 : 8;
            for (int l = 0; l < lists; l++) begin
               if ($urandom_range(0, 2) == 0) begin
                  put_bits(1, 1);
                  lastv = 8;
                  nextv = 8;
                  for (int j = 0; j < ((l < 6) ? 16 : 64) && nextv != 0; j++) begin
                     // often end the list by driving the scale to zero
                     d = ($urandom_range(0, 2) == 0) ? -int'(lastv)
                                                     : $urandom_range(0, 255) - 128;
                     dc = (d < 0) ? -2 * d - 1 : 2 * d;
                     put_ue(dc);
                     nextv = lastv + 8'(d);
                     if (nextv != 0) lastv = nextv;
                  end
               end else begin
                  put_bits(0, 1);
               end
            end
         end else begin
            put_bits(0, 1);
         end
      end
      put_ue($urandom_range(0, 12));
      poc = $urandom_range(0, 3);
      put_ue(poc);
      if (poc == 0) begin
         put_ue($urandom_range(0, 12));
      end else if (poc == 1) begin
         put_bits($urandom, 1);
         put_ue(pick_value());
         put_ue(pick_value());
         nref = $urandom_range(0, 3);
         put_ue(nref);
         for (int i = 0; i < nref; i++) put_ue(pick_value());
      end
      put_ue($urandom_range(0, 16));
      put_bits($urandom, 1);
      put_ue(pick_value());
      put_ue(pick_value());
      if ($urandom_range(0, 1)) begin
         put_bits(1, 1);
      end else begin
         put_bits(0, 1);
         put_bits($urandom, 1);
      end
      put_bits($urandom, 1);
      if ($urandom_range(0, 1)) begin
         put_bits(1, 1);
         for (int i = 0; i < 4; i++) put_ue(pick_value());
      end else begin
         put_bits(0, 1);
      end
      if ($urandom_range(0, 3) != 0) begin
         put_bits(1, 1);
         if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            if ($urandom_range(0, 1)) begin
               put_bits(255, 8);
               put_bits($urandom, 16);
               put_bits($urandom, 16);
            end else begin
               put_bits($urandom, 8);
            end
         end else begin
            put_bits(0, 1);
         end
         if ($urandom_range(0, 1)) begin put_bits(1, 1); put_bits($urandom, 1); end
         else put_bits(0, 1);
         if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            put_bits($urandom, 4);
            put_bits($urandom, 1);
            if ($urandom_range(0, 1)) begin put_bits(1, 1); put_bits($urandom, 24); end
            else put_bits(0, 1);
         end else begin
            put_bits(0, 1);
         end
         if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            put_ue($urandom_range(0, 5));
            put_ue($urandom_range(0, 5));
         end else begin
            put_bits(0, 1);
         end
         if ($urandom_range(0, 3) != 0) begin
            put_bits(1, 1);
            put_bits($urandom, 32);
            put_bits($urandom, 32);
            put_bits($urandom, 1);
         end else begin
            put_bits(0, 1);
         end
      end else begin
         put_bits(0, 1);
      end
   endtask

   // ---------------------------------------------------------------
   // request driver: bursts with gaps, holds until results drain
   // ---------------------------------------------------------------

   int burst_left = 0;
   int gap_left = 0;
   bit took;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            predict_byte(req_tdata, req_tlast);
            void'(byte_q.pop_front());
         end
         // a presented request stays up until taken
         if (!req_tvalid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_q.size() == 0 || (byte_q[0].hold && field_q.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= byte_q[0].data;
               req_tlast <= byte_q[0].last;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result side: stall pattern and field checker
   // ---------------------------------------------------------------

   int stall_mode = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   field_rec_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (field_q.size() == 0) begin
            $error("unexpected result: field_code %0d field_value %0h",
                   rsp_tdata[4:0], rsp_tdata[36:5]);
            fail_count++;
         end else begin
            want = field_q.pop_front();
            if (rsp_tdata[4:0] !== want.code) begin
               $error("field_code: expected %0d, got %0d", want.code, rsp_tdata[4:0]);
               fail_count++;
            end
            if (rsp_tdata[36:5] !== want.value) begin
               $error("field_value: expected %0h, got %0h", want.value, rsp_tdata[36:5]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("final_result: expected %0b, got %0b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------

   initial begin
      clear_parser();

      // short units: one byte and three bytes, each sometimes padded with random trailing bytes in the same unit
      put_bits(8'hff, 8);
      pack_unit(0, 0);
      put_bits($urandom, 24);
      pack_unit(0, 0);
      // four zero bytes: the id prefix hits the cap and reads a huge id
      put_bits(0, 32);
      pack_unit(0, 0);
      // four all-ones bytes: profile 255, id 0, the rest past the end
      put_bits(32'hffffffff, 32);
      pack_unit(0, 0);
      // capped prefix on the width, wraps the derived sizes; sent after a drain
      put_bits(66, 8);
      put_bits(8'hff, 8);
      put_bits(255, 8);
      put_ue(31);
      put_ue(0);
      put_ue(2);
      put_ue(0);
      put_bits(1, 1);
      put_bits(0, 31);
      put_bits(32'h7fffffff, 31);
      put_ue(32'hfffffffe);
      put_bits(1, 1);
      put_bits(0, 1);
      put_bits(0, 1);
      put_bits(0, 1);
      pack_unit(1, 0);

      // random part: mostly real parameter sets, some noise units
      while (byte_q.size() < 110) begin
         if ($urandom_range(0, 7) == 0) begin
            put_bits($urandom, 32);
            put_bits($urandom, 8 * $urandom_range(0, 3));
            pack_unit(0, 0);
         end else begin
            build_sps();
            pack_unit($urandom_range(0, 5) == 0, 1);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || field_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && field_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/h264sps_pkg.sv
hw/rtl/h264sps_syntax.sv
hw/rtl/h264_sps_header_parser.sv
sim/h264_sps_header_parser_tb.sv
